FILE: rtl/core/ehfx_pkg.sv
`timescale 1ns / 1ps
package ehfx_pkg;

	// only the first 40 bytes of any layer are ever read back
	localparam int StoreBytes = 40;
	localparam int IdxBits = $clog2(StoreBytes);
	localparam int OffBits = 7;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [15:0] ETYPE_ARP = 16'h0806;
	localparam logic [15:0] ETYPE_VLAN = 16'h8100;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

	localparam logic [3:0] IP4_VERSION = 4'd4;
	localparam logic [3:0] IP4_MIN_IHL = 4'd5;

	localparam logic [OffBits-1:0] LEN_ETH = 7'd14;
	localparam logic [OffBits-1:0] LEN_VLAN = 7'd4;
	localparam logic [OffBits-1:0] LEN_IPV4 = 7'd20;
	localparam logic [OffBits-1:0] LEN_IPV6 = 7'd40;
	localparam logic [OffBits-1:0] LEN_ARP = 7'd28;
	localparam logic [OffBits-1:0] LEN_TCP = 7'd20;
	localparam logic [OffBits-1:0] LEN_UDP = 7'd8;
	localparam logic [OffBits-1:0] LEN_ICMP = 7'd8;

	typedef logic [StoreBytes-1:0][7:0] hdr_bytes_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  field_code;
		logic [63:0] field_value;
		logic        run_last;
	} out_word_t;

	typedef enum logic [3:0] {
		PH_ETH, PH_VLAN, PH_IPV4, PH_IPV6, PH_ARP, PH_TCP, PH_UDP, PH_ICMP, PH_DONE
	} phase_e;

	typedef enum logic [2:0] {
		ST_OK, ST_TRUNC, ST_BADVER, ST_UNKNOWN, ST_MALFORMED
	} status_e;

	typedef enum logic [5:0] {
		F_STATUS, F_LENGTH, F_ETH_DST, F_ETH_SRC, F_ETH_TYPE, F_VLAN_TYPE,
		F_IP4_VER, F_IP4_IHL, F_IP4_TOS, F_IP4_TOTLEN, F_IP4_ID, F_IP4_FLAGS,
		F_IP4_FRAG, F_IP4_TTL, F_IP4_PROTO, F_IP4_CSUM, F_IP4_SRC, F_IP4_DST,
		F_TCP_SPORT, F_TCP_DPORT, F_TCP_SEQ, F_TCP_ACK, F_TCP_HLEN, F_TCP_FLAGS,
		F_TCP_WIN, F_TCP_CSUM, F_TCP_URG,
		F_UDP_SPORT, F_UDP_DPORT, F_UDP_LEN, F_UDP_CSUM,
		F_ICMP_TYPE, F_ICMP_CODE, F_ICMP_CSUM, F_ICMP_ID, F_ICMP_SEQ, F_ICMP_REST,
		F_IP6_VER, F_IP6_TC, F_IP6_FLOW, F_IP6_PLEN, F_IP6_NXT, F_IP6_HOP,
		F_IP6_SRC_HI, F_IP6_SRC_LO, F_IP6_DST_HI, F_IP6_DST_LO,
		F_ARP_HTYPE, F_ARP_PTYPE, F_ARP_HLEN, F_ARP_PLEN, F_ARP_OP,
		F_ARP_SHA, F_ARP_SPA, F_ARP_THA, F_ARP_TPA
	} field_code_e;

	// layer is PH_DONE when the byte completed no header
	typedef struct packed {
		phase_e  layer;
		logic    frame_end;
		status_e status;
	} job_t;

	typedef struct packed {
		field_code_e code;
		logic [63:0] value;
	} rec_t;

	function automatic logic icmp_is_echo(hdr_bytes_t h);
		return (h[0] == ICMP_ECHO_REPLY) || (h[0] == ICMP_ECHO_REQUEST);
	endfunction

	function automatic logic [3:0] layer_count(phase_e k, hdr_bytes_t h);
		logic [3:0] n;
		unique case (k)
			PH_ETH:  n = 4'd3;
			PH_VLAN: n = 4'd1;
			PH_IPV4: n = 4'd12;
			PH_TCP:  n = 4'd9;
			PH_UDP:  n = 4'd4;
			PH_ICMP: n = icmp_is_echo(h) ? 4'd5 : 4'd4;
			PH_IPV6: n = 4'd10;
			PH_ARP:  n = 4'd9;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic rec_t layer_record(phase_e k, logic [3:0] idx, hdr_bytes_t h);
		rec_t r;
		r.code = F_STATUS;
		r.value = '0;
		unique case (k)
			PH_ETH: begin
				unique case (idx)
					4'd0: r = '{F_ETH_DST, 64'({h[0], h[1], h[2], h[3], h[4], h[5]})};
					4'd1: r = '{F_ETH_SRC, 64'({h[6], h[7], h[8], h[9], h[10], h[11]})};
					default: r = '{F_ETH_TYPE, 64'({h[12], h[13]})};
				endcase
			end
			PH_VLAN: r = '{F_VLAN_TYPE, 64'({h[2], h[3]})};
			PH_IPV4: begin
				unique case (idx)
					4'd0: r = '{F_IP4_VER, 64'(h[0][7:4])};
					4'd1: r = '{F_IP4_IHL, 64'(h[0][3:0])};
					4'd2: r = '{F_IP4_TOS, 64'(h[1])};
					4'd3: r = '{F_IP4_TOTLEN, 64'({h[2], h[3]})};
					4'd4: r = '{F_IP4_ID, 64'({h[4], h[5]})};
					4'd5: r = '{F_IP4_FLAGS, 64'(h[6][7:5])};
					4'd6: r = '{F_IP4_FRAG, 64'({h[6][4:0], h[7]})};
					4'd7: r = '{F_IP4_TTL, 64'(h[8])};
					4'd8: r = '{F_IP4_PROTO, 64'(h[9])};
					4'd9: r = '{F_IP4_CSUM, 64'({h[10], h[11]})};
					4'd10: r = '{F_IP4_SRC, 64'({h[12], h[13], h[14], h[15]})};
					default: r = '{F_IP4_DST, 64'({h[16], h[17], h[18], h[19]})};
				endcase
			end
			PH_TCP: begin
				unique case (idx)
					4'd0: r = '{F_TCP_SPORT, 64'({h[0], h[1]})};
					4'd1: r = '{F_TCP_DPORT, 64'({h[2], h[3]})};
					4'd2: r = '{F_TCP_SEQ, 64'({h[4], h[5], h[6], h[7]})};
					4'd3: r = '{F_TCP_ACK, 64'({h[8], h[9], h[10], h[11]})};
					4'd4: r = '{F_TCP_HLEN, 64'({h[12][7:4], 2'b00})};
					4'd5: r = '{F_TCP_FLAGS, 64'(h[13])};
					4'd6: r = '{F_TCP_WIN, 64'({h[14], h[15]})};
					4'd7: r = '{F_TCP_CSUM, 64'({h[16], h[17]})};
					default: r = '{F_TCP_URG, 64'({h[18], h[19]})};
				endcase
			end
			PH_UDP: begin
				unique case (idx)
					4'd0: r = '{F_UDP_SPORT, 64'({h[0], h[1]})};
					4'd1: r = '{F_UDP_DPORT, 64'({h[2], h[3]})};
					4'd2: r = '{F_UDP_LEN, 64'({h[4], h[5]})};
					default: r = '{F_UDP_CSUM, 64'({h[6], h[7]})};
				endcase
			end
			PH_ICMP: begin
				unique case (idx)
					4'd0: r = '{F_ICMP_TYPE, 64'(h[0])};
					4'd1: r = '{F_ICMP_CODE, 64'(h[1])};
					4'd2: r = '{F_ICMP_CSUM, 64'({h[2], h[3]})};
					4'd3: begin
						if (icmp_is_echo(h)) begin
							r = '{F_ICMP_ID, 64'({h[4], h[5]})};
						end else begin
							r = '{F_ICMP_REST, 64'({h[4], h[5], h[6], h[7]})};
						end
					end
					default: r = '{F_ICMP_SEQ, 64'({h[6], h[7]})};
				endcase
			end
			PH_IPV6: begin
				unique case (idx)
					4'd0: r = '{F_IP6_VER, 64'(h[0][7:4])};
					4'd1: r = '{F_IP6_TC, 64'({h[0][3:0], h[1][7:4]})};
					4'd2: r = '{F_IP6_FLOW, 64'({h[1][3:0], h[2], h[3]})};
					4'd3: r = '{F_IP6_PLEN, 64'({h[4], h[5]})};
					4'd4: r = '{F_IP6_NXT, 64'(h[6])};
					4'd5: r = '{F_IP6_HOP, 64'(h[7])};
					4'd6: r = '{F_IP6_SRC_HI,
						{h[8], h[9], h[10], h[11], h[12], h[13], h[14], h[15]}};
					4'd7: r = '{F_IP6_SRC_LO,
						{h[16], h[17], h[18], h[19], h[20], h[21], h[22], h[23]}};
					4'd8: r = '{F_IP6_DST_HI,
						{h[24], h[25], h[26], h[27], h[28], h[29], h[30], h[31]}};
					default: r = '{F_IP6_DST_LO,
						{h[32], h[33], h[34], h[35], h[36], h[37], h[38], h[39]}};
				endcase
			end
			PH_ARP: begin
				unique case (idx)
					4'd0: r = '{F_ARP_HTYPE, 64'({h[0], h[1]})};
					4'd1: r = '{F_ARP_PTYPE, 64'({h[2], h[3]})};
					4'd2: r = '{F_ARP_HLEN, 64'(h[4])};
					4'd3: r = '{F_ARP_PLEN, 64'(h[5])};
					4'd4: r = '{F_ARP_OP, 64'({h[6], h[7]})};
					4'd5: r = '{F_ARP_SHA, 64'({h[8], h[9], h[10], h[11], h[12], h[13]})};
					4'd6: r = '{F_ARP_SPA, 64'({h[14], h[15], h[16], h[17]})};
					4'd7: r = '{F_ARP_THA, 64'({h[18], h[19], h[20], h[21], h[22], h[23]})};
					default: r = '{F_ARP_TPA, 64'({h[24], h[25], h[26], h[27]})};
				endcase
			end
			default: r = '{F_STATUS, 64'd0};
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/ehfx_layer_tracker.sv
`timescale 1ns / 1ps
module ehfx_layer_tracker import ehfx_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  in_word_t               word,
	output hdr_bytes_t             store,
	output job_t                   job,
	output logic [LENGTH_BITS-1:0] frame_len
);

	phase_e                 phase_q, phase_d;
	logic [OffBits-1:0]     off_q, off_d;
	logic [OffBits-1:0]     need_q, need_d;
	status_e                status_d, status_q;
	logic [LENGTH_BITS-1:0] pos_q, pos_d, pos_inc;
	hdr_bytes_t             store_q, h;
	logic                   active, complete, do_dispatch;
	logic [15:0]            etype;
	logic [OffBits-1:0]     ihl_bytes, tcp_bytes;

	always_comb begin
		h = store_q;
		if (off_q < OffBits'(StoreBytes)) begin
			h[off_q[IdxBits-1:0]] = word.data_byte;
		end

		active = (phase_q != PH_DONE);
		complete = active && ((off_q + 7'd1) == need_q);
		ihl_bytes = OffBits'({h[0][3:0], 2'b00});
		tcp_bytes = OffBits'({h[12][7:4], 2'b00});

		phase_d = phase_q;
		off_d = active ? off_q + 7'd1 : off_q;
		need_d = need_q;
		status_d = status_q;
		job.layer = PH_DONE;
		do_dispatch = 1'b0;
		etype = {h[12], h[13]};

		if (complete) begin
			unique case (phase_q)
				PH_ETH: begin
					job.layer = PH_ETH;
					if (etype == ETYPE_VLAN) begin
						phase_d = PH_VLAN;
						need_d = LEN_VLAN;
						off_d = '0;
					end else begin
						do_dispatch = 1'b1;
					end
				end
				PH_VLAN: begin
					job.layer = PH_VLAN;
					etype = {h[2], h[3]};
					do_dispatch = 1'b1;
				end
				PH_IPV4: begin
					if (h[0][7:4] != IP4_VERSION) begin
						phase_d = PH_DONE;
						status_d = ST_BADVER;
					end else if (h[0][3:0] < IP4_MIN_IHL) begin
						phase_d = PH_DONE;
						status_d = ST_MALFORMED;
					end else if (ihl_bytes > need_q) begin
						// options present, keep collecting
						need_d = ihl_bytes;
					end else begin
						job.layer = PH_IPV4;
						off_d = '0;
						priority if (h[9] == PROTO_TCP) begin
							phase_d = PH_TCP;
							need_d = LEN_TCP;
						end else if (h[9] == PROTO_UDP) begin
							phase_d = PH_UDP;
							need_d = LEN_UDP;
						end else if (h[9] == PROTO_ICMP) begin
							phase_d = PH_ICMP;
							need_d = LEN_ICMP;
						end else begin
							phase_d = PH_DONE;
							status_d = ST_UNKNOWN;
						end
					end
				end
				PH_TCP: begin
					if (tcp_bytes > need_q) begin
						need_d = tcp_bytes;
					end else begin
						job.layer = PH_TCP;
						phase_d = PH_DONE;
					end
				end
				PH_UDP, PH_ICMP, PH_IPV6, PH_ARP: begin
					job.layer = phase_q;
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end

		if (do_dispatch) begin
			off_d = '0;
			priority if (etype == ETYPE_IPV4) begin
				phase_d = PH_IPV4;
				need_d = LEN_IPV4;
			end else if (etype == ETYPE_IPV6) begin
				phase_d = PH_IPV6;
				need_d = LEN_IPV6;
			end else if (etype == ETYPE_ARP) begin
				phase_d = PH_ARP;
				need_d = LEN_ARP;
			end else begin
				phase_d = PH_DONE;
				status_d = ST_UNKNOWN;
			end
		end

		// byte count saturates at all ones
		pos_inc = (pos_q == '1) ? pos_q : pos_q + LENGTH_BITS'(1);
		pos_d = pos_inc;
		job.frame_end = word.frame_last;
		job.status = (phase_d != PH_DONE) ? ST_TRUNC : status_d;
		frame_len = pos_inc;

		if (word.frame_last) begin
			phase_d = PH_ETH;
			off_d = '0;
			need_d = LEN_ETH;
			status_d = ST_OK;
			pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ETH;
			off_q <= '0;
			need_q <= LEN_ETH;
			status_q <= ST_OK;
			pos_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			off_q <= off_d;
			need_q <= need_d;
			status_q <= status_d;
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && active) begin
			store_q <= h;
		end
	end

	assign store = store_q;

endmodule

FILE: rtl/core/ehfx_record_gen.sv
`timescale 1ns / 1ps
module ehfx_record_gen import ehfx_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  job_t                   job_in,
	input  logic [LENGTH_BITS-1:0] len_in,
	input  hdr_bytes_t             store,
	output logic                   busy,
	output logic                   rec_valid,
	input  logic                   rec_ready,
	output out_word_t              rec_word
);

	logic                   busy_q;
	job_t                   job_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [3:0]             idx_q, n_layer, n_total, end_idx;
	logic                   out_valid_q, advance, is_last, job_has_recs;
	out_word_t              out_q;
	rec_t                   rec;

	always_comb begin
		n_layer = layer_count(job_q.layer, store);
		n_total = n_layer + (job_q.frame_end ? 4'd2 : 4'd0);
		is_last = (idx_q == n_total - 4'd1);
		end_idx = idx_q - n_layer;
		if (idx_q < n_layer) begin
			rec = layer_record(job_q.layer, idx_q, store);
		end else if (end_idx == 4'd0) begin
			rec = '{F_STATUS, 64'(job_q.status)};
		end else begin
			rec = '{F_LENGTH, 64'(len_q)};
		end
		advance = busy_q && (!out_valid_q || rec_ready);
		job_has_recs = (job_in.layer != PH_DONE) || job_in.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rec_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= job_has_recs;
				idx_q <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 4'd1;
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job_in;
			len_q <= len_in;
		end
		if (advance) begin
			out_q.field_code <= rec.code;
			out_q.field_value <= rec.value;
			out_q.run_last <= is_last;
		end
	end

	assign busy = busy_q;
	assign rec_valid = out_valid_q;
	assign rec_word = out_q;

endmodule

FILE: rtl/core/ethernet_ip_header_field_extractor.sv
`timescale 1ns / 1ps
// Ethernet / 802.1Q / IPv4 / IPv6 / ARP / TCP / UDP / ICMP header field extractor.
// byte channel: one frame byte per word, frame_last on the final byte of a frame.
// rec channel: one field record per word; run_last marks the final record that a
// given input byte produced.
// A byte that completes a header, or ends the frame, starts a run of records
// (up to 14). The sequencer latches the byte's job when it is accepted, then
// registers the first record; the rest follow one per cycle while rec_ready
// is high. The sequencer thus sets the rate: bytes that produce no record
// are taken every cycle; a byte that produces records holds byte_ready low
// until its last record has been registered, which waits on rec_ready.
// The header bytes are held still in the meantime, so records are read from them.
// A stalled receiver simply holds the output register and the sequencer; bytes
// keep flowing until the next byte that produces records.
// Reset clears the parse state to "expecting an Ethernet header", with byte
// count zero and status ok; the header byte store has no reset.
module ethernet_ip_header_field_extractor import ehfx_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_ready,
	input  in_word_t  byte_word,
	output logic      rec_valid,
	input  logic      rec_ready,
	output out_word_t rec_word
);

	logic                   accept, busy;
	hdr_bytes_t             store;
	job_t                   job;
	logic [LENGTH_BITS-1:0] frame_len;

	assign byte_ready = !busy;
	assign accept = byte_valid && byte_ready;

	ehfx_layer_tracker #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.word      (byte_word),
		.store     (store),
		.job       (job),
		.frame_len (frame_len)
	);

	ehfx_record_gen #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_recgen (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.job_in    (job),
		.len_in    (frame_len),
		.store     (store),
		.busy      (busy),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec_word  (rec_word)
	);

endmodule
